// ===== design/lvmf_pkg.sv =====
// Shared command codes and controller/datapath interface types for the membership filter.
package lvmf_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic clear;     // empty the value set
    logic add;       // append the word to the value set
    logic search;    // compare the word and emit on a hit
    logic advance;   // step the list position
    logic restart;   // return the list position to zero
  } lvmf_ctl_t;

  typedef struct packed {
    logic pos_last;  // list position sits at the last in-bound slot
    logic set_full;  // every set slot holds a value
  } lvmf_sts_t;

endpackage

// ===== design/list_value_membership_filter.sv =====
// Top level of the list value membership filter.
// Takes one command beat every clock cycle (busy stays low): clear the value
// set, add a value, or search a list item against all stored values at once.
// A matching search within the list bound gives one result beat, strobe high
// for one cycle, on the cycle after the command; the position is the item's
// place in its list and restarts after an item marked list_end. The parallel
// compare over SET_SLOTS values sets the rate; results cannot be held off.
module list_value_membership_filter #(
  parameter int SET_SLOTS  = 16,
  parameter int WORD_BITS  = 32,
  parameter int LIST_BOUND = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [WORD_BITS-1:0] word,
  input  logic                 list_end,
  output logic                 strobe,
  output logic [15:0]          position,
  output logic                 from_last_item
);
  import lvmf_pkg::*;

  lvmf_ctl_t ctl;
  lvmf_sts_t sts;
  logic      take;

  assign busy = 1'b0;
  assign take = start && !busy;

  lvmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (cmd),
    .list_end (list_end),
    .sts      (sts),
    .ctl      (ctl)
  );

  lvmf_dp #(
    .SET_SLOTS  (SET_SLOTS),
    .WORD_BITS  (WORD_BITS),
    .LIST_BOUND (LIST_BOUND)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .word           (word),
    .list_end       (list_end),
    .sts            (sts),
    .strobe         (strobe),
    .position       (position),
    .from_last_item (from_last_item)
  );

endmodule

// ===== design/lvmf_ctrl.sv =====
// Controller: decodes each command beat and tracks whether the list is past its bound.
module lvmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [1:0]        cmd,
  input  logic              list_end,
  input  lvmf_pkg::lvmf_sts_t sts,
  output lvmf_pkg::lvmf_ctl_t ctl
);
  import lvmf_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_PAST = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    if (take) begin
      unique case (cmd)
        CMD_CLEAR: ctl.clear = 1'b1;
        CMD_ADD:   ctl.add = !sts.set_full;
        CMD_SEARCH: begin
          unique case (state)
            ST_RUN: begin
              ctl.search  = 1'b1;
              ctl.advance = !list_end;
              if (!list_end && sts.pos_last) begin
                state_next = ST_PAST;
              end
            end
            ST_PAST: begin
              // drop the item; only a list end brings the position back
              if (list_end) begin
                state_next = ST_RUN;
              end
            end
            default: state_next = ST_RUN;
          endcase
          ctl.restart = list_end;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/lvmf_dp.sv =====
// Datapath: value set, set count, list position counter and the result register.
module lvmf_dp #(
  parameter int SET_SLOTS  = 16,
  parameter int WORD_BITS  = 32,
  parameter int LIST_BOUND = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lvmf_pkg::lvmf_ctl_t  ctl,
  input  logic [WORD_BITS-1:0] word,
  input  logic                 list_end,
  output lvmf_pkg::lvmf_sts_t  sts,
  output logic                 strobe,
  output logic [15:0]          position,
  output logic                 from_last_item
);
  import lvmf_pkg::*;

  localparam int CNT_BITS = $clog2(SET_SLOTS + 1);
  localparam int IDX_BITS = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;
  localparam int POS_BITS = $clog2(LIST_BOUND);
  localparam logic [CNT_BITS-1:0] SLOTS_C = CNT_BITS'(SET_SLOTS);
  localparam logic [POS_BITS-1:0] POS_LAST_C = POS_BITS'(LIST_BOUND - 1);

  logic [WORD_BITS-1:0] slots [SET_SLOTS];
  logic [CNT_BITS-1:0]  count;
  logic [POS_BITS-1:0]  pos;
  logic                 hit;
  logic [POS_BITS+15:0] pos_ext;

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < SET_SLOTS; k++) begin
      if ((CNT_BITS'(k) < count) && (slots[k] == word)) begin
        hit = 1'b1;
      end
    end
  end

  assign sts.set_full = (count == SLOTS_C);
  assign sts.pos_last = (pos == POS_LAST_C);
  assign pos_ext      = {16'd0, pos};

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      slots[count[IDX_BITS-1:0]] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else begin
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.add) begin
        count <= count + 1'b1;
      end
      // hold the position at the last slot once past the bound
      if (ctl.restart) begin
        pos <= '0;
      end else if (ctl.advance && !sts.pos_last) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.search && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.search) begin
      position       <= pos_ext[15:0];
      from_last_item <= list_end;
    end
  end

endmodule
